### rtl/core/bhsd_pkg.sv
// Shared types, sizes and the dither threshold for the half-shrink block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package bhsd_pkg;

  localparam int LINE_WORDS = 64;
  localparam int LANES      = 16;
  localparam int IDX_W      = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int COL_W      = $clog2(LINE_WORDS + 1);

  localparam logic [COL_W-1:0] LINE_WORDS_C = COL_W'(LINE_WORDS);

  localparam logic [0:0] REG_DARK_MODE  = 1'b0;
  localparam logic [0:0] REG_ROW_PHASE  = 1'b1;

  typedef struct packed {
    logic [31:0] src_word;
    logic        end_of_row;
    logic        start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dest_bits;
    logic        dest_row_end;
  } out_item_t;

  // Control that travels with an odd-row word from the buffer read stage
  // to the lanes.
  typedef struct packed {
    logic valid;
    logic row_end;
    logic row_par;
    logic past_end;
  } s1_ctl_t;

  // Ordered-dither threshold {0,2;3,1} by destination row and column parity.
  function automatic logic [1:0] dither_thr(input logic row_par, input logic col_par);
    logic [1:0] thr;
    unique case ({row_par, col_par})
      2'b00:   thr = 2'd0;
      2'b01:   thr = 2'd2;
      2'b10:   thr = 2'd3;
      default: thr = 2'd1;
    endcase
    return thr;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bhsd_lane.sv
// One count-and-compare lane: sums the set pixels of a 2x2 block and
// compares against the threshold. Uses bhsd_pkg for the dither table.
`default_nettype none

module bhsd_lane (
  input  wire logic [1:0] upper_pair,
  input  wire logic [1:0] lower_pair,
  input  wire logic       dark_mode,
  input  wire logic       row_par,
  input  wire logic       col_par,
  output logic            dest_bit
);

  logic [2:0] count;
  logic [2:0] thr;

  always_comb begin
    count = 3'(upper_pair[1]) + 3'(upper_pair[0]) + 3'(lower_pair[1]) + 3'(lower_pair[0]);
    thr   = dark_mode ? 3'd1 : {1'b0, bhsd_pkg::dither_thr(row_par, col_par)};
    dest_bit = (count > thr);
  end

endmodule

`default_nettype wire

### rtl/core/bhsd_merge.sv
// Merging stage: gathers the sixteen lane bits into one result word and
// holds it in the output register. Uses bhsd_pkg types.
`default_nettype none

module bhsd_merge (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bhsd_pkg::s1_ctl_t         s1_ctl,
  input  wire logic [bhsd_pkg::LANES-1:0] lane_bits,
  output logic                           out_free,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bhsd_pkg::out_item_t            out_data
);

  logic                valid_r;
  logic                valid_nxt;
  bhsd_pkg::out_item_t data_r;
  logic                load;

  always_comb begin
    out_free  = !valid_r || !out_stall;
    load      = s1_ctl.valid && out_free;
    valid_nxt = load ? 1'b1 : (out_free ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.dest_bits    <= lane_bits;
      data_r.dest_row_end <= s1_ctl.row_end;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/core/bhsd_front.sv
// Row and column tracking plus the even-row line store. Odd-row words read
// the stored word of their column into the lane stage. Uses bhsd_pkg.
`default_nettype none

module bhsd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire bhsd_pkg::in_item_t  in_data,
  input  wire logic                s1_take,
  input  wire logic                row_phase,
  output bhsd_pkg::s1_ctl_t        s1_ctl,
  output logic [31:0]              upper_word,
  output logic [31:0]              lower_word
);

  logic [31:0] line_mem [bhsd_pkg::LINE_WORDS];

  logic [bhsd_pkg::COL_W-1:0] col_r, col_nxt, col_eff;
  logic                       odd_r, odd_nxt, odd_eff;
  logic                       par_r, par_nxt, par_eff;
  logic                       in_range;
  bhsd_pkg::s1_ctl_t          s1_r, s1_nxt;
  logic [31:0]                rdata_r;
  logic [31:0]                lower_r;

  always_comb begin
    // A frame start restarts row and column before this word is used.
    col_eff  = in_data.start_of_frame ? '0 : col_r;
    odd_eff  = in_data.start_of_frame ? 1'b0 : odd_r;
    par_eff  = in_data.start_of_frame ? row_phase : par_r;
    in_range = (col_eff < bhsd_pkg::LINE_WORDS_C);

    col_nxt = col_r;
    odd_nxt = odd_r;
    par_nxt = par_r;
    if (accept) begin
      if (in_data.end_of_row) begin
        col_nxt = '0;
        odd_nxt = !odd_eff;
        par_nxt = odd_eff ? !par_eff : par_eff;
      end else begin
        col_nxt = in_range ? col_eff + 1'b1 : col_eff;
        odd_nxt = odd_eff;
        par_nxt = par_eff;
      end
    end

    s1_nxt = s1_r;
    if (accept && odd_eff) begin
      s1_nxt.valid    = 1'b1;
      s1_nxt.row_end  = in_data.end_of_row;
      s1_nxt.row_par  = par_eff;
      s1_nxt.past_end = !in_range;
    end else if (s1_take) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      odd_r      <= 1'b0;
      par_r      <= 1'b0;
      s1_r.valid <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      odd_r      <= odd_nxt;
      par_r      <= par_nxt;
      s1_r.valid <= s1_nxt.valid;
    end
    s1_r.row_end  <= s1_nxt.row_end;
    s1_r.row_par  <= s1_nxt.row_par;
    s1_r.past_end <= s1_nxt.past_end;
  end

  always_ff @(posedge clk) begin
    if (accept && !odd_eff && in_range) begin
      line_mem[col_eff[bhsd_pkg::IDX_W-1:0]] <= in_data.src_word;
    end
    if (accept && odd_eff) begin
      rdata_r <= line_mem[col_eff[bhsd_pkg::IDX_W-1:0]];
      lower_r <= in_data.src_word;
    end
  end

  // Columns beyond the buffer take the upper row as blank.
  assign upper_word = s1_r.past_end ? 32'd0 : rdata_r;
  assign lower_word = lower_r;
  assign s1_ctl     = s1_r;

endmodule

`default_nettype wire

### rtl/core/bitmap_half_shrink_dither.sv
// Top level of the 2x2 box downscaler with ordered dither.
// Uses bhsd_pkg, bhsd_front, bhsd_lane and bhsd_merge.
//
// Usage: source rows arrive on the in_ channel as 32-pixel words, leftmost
// pixel in the MSB, with end_of_row on the last word of each row and
// start_of_frame on the first word of an image. Words of even rows are kept
// in a 64-word line store and give no result. Each odd-row word gives one
// 16-bit result on the out_ channel, dest_row_end marking the row's last.
// One word is taken every cycle while in_stall is low. A transferred word
// is first registered at the line store read, then passes through the sixteen
// parallel lanes into the output register. The store's registered read port
// forms that first register.
// When the receiver stalls, the output register holds its word and the read
// stage can hold one more odd-row word; while it holds one, in_stall follows
// out_stall in the same cycle until the output register frees.
// Reset clears the row, column and dither parity state and both registers;
// the line store holds nothing meaningful until an even row writes it.
// The APB port writes dark_mode at address 0 and dither_row_phase at 4;
// the phase takes effect at the next start_of_frame.
`default_nettype none

module bitmap_half_shrink_dither (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bhsd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bhsd_pkg::out_item_t      out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic                         dark_mode_r;
  logic                         row_phase_r;
  logic                         accept;
  logic                         out_free;
  bhsd_pkg::s1_ctl_t            s1_ctl;
  logic [31:0]                  upper_word;
  logic [31:0]                  lower_word;
  logic [bhsd_pkg::LANES-1:0]   lane_bits;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_mode_r <= 1'b0;
      row_phase_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2:2])
        bhsd_pkg::REG_DARK_MODE: dark_mode_r <= pwdata[0];
        bhsd_pkg::REG_ROW_PHASE: row_phase_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      bhsd_pkg::REG_DARK_MODE: prdata = {31'd0, dark_mode_r};
      bhsd_pkg::REG_ROW_PHASE: prdata = {31'd0, row_phase_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // The read stage may take a new word whenever its content moves on.
  assign in_stall = s1_ctl.valid && !out_free;
  assign accept   = in_valid && !in_stall;

  bhsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .s1_take    (out_free),
    .row_phase  (row_phase_r),
    .s1_ctl     (s1_ctl),
    .upper_word (upper_word),
    .lower_word (lower_word)
  );

  for (genvar i = 0; i < bhsd_pkg::LANES; i++) begin : g_lane
    bhsd_lane u_lane (
      .upper_pair (upper_word[31-2*i -: 2]),
      .lower_pair (lower_word[31-2*i -: 2]),
      .dark_mode  (dark_mode_r),
      .row_par    (s1_ctl.row_par),
      .col_par    (1'(i % 2)),
      .dest_bit   (lane_bits[bhsd_pkg::LANES-1-i])
    );
  end

  bhsd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .lane_bits (lane_bits),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
